// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BFA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfa_pkg.sv =====
// ---------------------------------------------------------------------------
// bfa_pkg
// Types, codes, constants and helpers for the bitmap frame allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int MAX_FRAMES_DEF    = 65536;
  localparam int FRAME_SHIFT_DEF   = 12;
  localparam int BITS_PER_WORD_DEF = 8;

  localparam int ADDR_W     = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]  TOTAL_FRAMES_RST    = 17'h10000;
  localparam logic [ADDR_W-1:0] PROTECTED_BELOW_RST = 32'h0010_0000;

  // summary word width and search group width
  localparam int SUM_W     = 64;
  localparam int SUM_IDX_W = 6;
  localparam int GRP_W     = 16;
  localparam int LSB_W     = 64;
  localparam int LSB_IDX_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE          = 2'd0,
    ST_NO_CHANGE     = 2'd1,
    ST_OUT_OF_MEMORY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES    = 1'b0,
    CFG_PROTECTED_BELOW = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 found;
    logic [LSB_IDX_W-1:0] idx;
  } lsb_t;

  // lowest set bit
  function automatic lsb_t lsb64(input logic [LSB_W-1:0] v);
    lsb_t r;
    r = '0;
    for (int i = LSB_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = LSB_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bitmap_frame_allocator.sv =====
// ---------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a used-bit map held in RAM.
// ---------------------------------------------------------------------------
// The frame map lives in a word RAM (one used bit per frame), with a second
// RAM of summary words marking map words that hold a free frame, and one
// flip-flop per summary word on top. A free, reserve or release item has the
// map and summary words read as it is accepted, then modifies and writes
// both back, then loads the output register; one out of range, or a free
// below the protected address, goes straight to the output load. An
// allocate first picks the lowest summary word with a free frame from the
// flip-flops (kept by a registered search) and reads it, then finds the map
// word and reads it, then does the same write-back and output load; with no
// summary word marked free it goes straight to the output load. Each RAM has
// a single read and a single write port, so one item is in flight at a time;
// the next item can be accepted while a result waits in the output register,
// but its own result then holds in the output step until that register is
// free. After reset the map is swept to all-used, one word per cycle, during
// which in_stall stays high; configuration writes are taken throughout.
`timescale 1ns / 1ps

module bitmap_frame_allocator #(
  parameter int MAX_FRAMES    = bfa_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_SHIFT   = bfa_pkg::FRAME_SHIFT_DEF,
  parameter int BITS_PER_WORD = bfa_pkg::BITS_PER_WORD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bfa_pkg::OP_W-1:0]         in_operation,
  input  logic [bfa_pkg::ADDR_W-1:0]       in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bfa_pkg::ADDR_W-1:0]       out_result_address,
  output logic [bfa_pkg::STATUS_W-1:0]     out_status,
  output logic [bfa_pkg::CNT_W-1:0]        out_used_count,
  output logic [bfa_pkg::CNT_W-1:0]        out_free_count_out,
  input  logic                             cfg_wr_en,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WORD_W  = 1 << $clog2(BITS_PER_WORD);
  localparam int B_W     = $clog2(WORD_W);
  localparam int N0      = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int W_IDX_W = (N0 > 1) ? $clog2(N0) : 1;
  localparam int SUM_W   = bfa_pkg::SUM_W;
  localparam int SB_W    = bfa_pkg::SUM_IDX_W;
  localparam int N1      = (N0 + SUM_W - 1) / SUM_W;
  localparam int N1_W    = (N1 > 1) ? $clog2(N1) : 1;
  localparam int XW      = N1_W + SB_W;
  localparam int AFR_W   = bfa_pkg::ADDR_W - FRAME_SHIFT;
  localparam int LIM_W   = $clog2(MAX_FRAMES + 1);
  localparam int CW      = (LIM_W > bfa_pkg::CNT_W) ? LIM_W : bfa_pkg::CNT_W;
  localparam int FW0     = (AFR_W > W_IDX_W + B_W) ? AFR_W : W_IDX_W + B_W;
  localparam int FW      = (FW0 > LIM_W) ? FW0 : LIM_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PICK  = 6'b000100,
    S_SUM   = 6'b001000,
    S_MOD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [W_IDX_W-1:0]               clr_r, clr_nxt;
  bfa_pkg::op_t                     op_r, op_nxt;
  logic [W_IDX_W-1:0]               w_r, w_nxt;
  logic [B_W-1:0]                   b_r, b_nxt;
  bfa_pkg::status_t                 status_r, status_nxt;
  logic [bfa_pkg::ADDR_W-1:0]       res_r, res_nxt;
  logic [LIM_W-1:0]                 free_cnt_r, free_cnt_nxt;
  logic [bfa_pkg::CNT_W-1:0]        total_frames_r;
  logic [bfa_pkg::ADDR_W-1:0]       protected_below_r;

  logic                             out_valid_r, out_valid_nxt;
  logic [bfa_pkg::ADDR_W-1:0]       out_res_r, out_res_nxt;
  bfa_pkg::status_t                 out_status_r, out_status_nxt;
  logic [bfa_pkg::CNT_W-1:0]        out_used_r, out_used_nxt;
  logic [bfa_pkg::CNT_W-1:0]        out_free_r, out_free_nxt;

  // limit and incoming frame decode
  logic [CW-1:0]                    tf_x, limit_c;
  logic [LIM_W-1:0]                 limit;
  logic [FW-1:0]                    limit_x;
  logic [AFR_W-1:0]                 in_frame;
  logic [FW-1:0]                    in_frame_x;
  logic                             in_range;
  logic                             guarded;
  logic [W_IDX_W-1:0]               in_word;
  logic [B_W-1:0]                   in_bit;
  logic [XW-1:0]                    in_word_x;
  logic [N1_W-1:0]                  in_i1;

  logic [XW-1:0]                    w_x;
  logic [N1_W-1:0]                  cur_i1;
  logic [SB_W-1:0]                  cur_s;
  logic [XW-1:0]                    pick_x;
  logic [XW-1:0]                    sum_word_x;
  logic [XW-1:0]                    clr_x;

  // RAM ports
  logic                             l0_we, l1_we;
  logic [W_IDX_W-1:0]               l0_waddr, l0_raddr;
  logic [N1_W-1:0]                  l1_waddr, l1_raddr;
  logic [WORD_W-1:0]                l0_wdata, l0_rdata;
  logic [SUM_W-1:0]                 l1_wdata, l1_rdata;

  logic                             pick_found;
  logic [N1_W-1:0]                  pick_idx;
  logic                             upd_en;
  logic                             upd_val;

  // read-modify-write datapath
  bfa_pkg::lsb_t                    l1_lsb, l0_lsb;
  logic [WORD_W-1:0]                free_bits;
  logic [B_W-1:0]                   mod_bit;
  logic                             mod_set;
  logic [FW-1:0]                    mod_frame_x;
  logic                             mod_change;
  logic [WORD_W-1:0]                bit_mask, new_word;
  logic [SUM_W-1:0]                 sum_mask, new_sum;
  logic                             word_nonfull;
  logic [bfa_pkg::ADDR_W-1:0]       mod_addr;
  logic [LIM_W-1:0]                 used_cnt;

  assign tf_x    = CW'(total_frames_r);
  assign limit_c = (tf_x < CW'(MAX_FRAMES)) ? tf_x : CW'(MAX_FRAMES);
  assign limit   = limit_c[LIM_W-1:0];
  assign limit_x = FW'(limit);

  assign in_frame   = in_address[bfa_pkg::ADDR_W-1:FRAME_SHIFT];
  assign in_frame_x = FW'(in_frame);
  assign in_range   = in_frame_x < limit_x;
  assign guarded    = (bfa_pkg::op_t'(in_operation) == bfa_pkg::OP_FREE) &&
                      (in_address < protected_below_r);
  assign in_word    = in_frame_x[B_W +: W_IDX_W];
  assign in_bit     = in_frame_x[B_W-1:0];
  assign in_word_x  = XW'(in_word);
  assign in_i1      = in_word_x[XW-1:SB_W];

  assign w_x        = XW'(w_r);
  assign cur_i1     = w_x[XW-1:SB_W];
  assign cur_s      = w_x[SB_W-1:0];
  assign pick_x     = {pick_idx, {SB_W{1'b0}}};
  assign l1_lsb     = bfa_pkg::lsb64(l1_rdata);
  assign sum_word_x = {cur_i1, l1_lsb.idx};
  assign clr_x      = XW'(clr_r);

  assign free_bits    = ~l0_rdata;
  assign l0_lsb       = bfa_pkg::lsb64(bfa_pkg::LSB_W'(free_bits));
  assign mod_bit      = (op_r == bfa_pkg::OP_ALLOC) ? l0_lsb.idx[B_W-1:0] : b_r;
  assign mod_set      = (op_r == bfa_pkg::OP_ALLOC) || (op_r == bfa_pkg::OP_RESERVE);
  assign mod_frame_x  = FW'({w_r, mod_bit});
  assign mod_change   = (op_r == bfa_pkg::OP_ALLOC) ?
                        (l0_lsb.found && (mod_frame_x < limit_x)) :
                        (l0_rdata[b_r] != mod_set);
  assign bit_mask     = WORD_W'(1) << mod_bit;
  assign new_word     = mod_set ? (l0_rdata | bit_mask) : (l0_rdata & ~bit_mask);
  assign word_nonfull = new_word != '1;
  assign sum_mask     = SUM_W'(1) << cur_s;
  assign new_sum      = word_nonfull ? (l1_rdata | sum_mask) : (l1_rdata & ~sum_mask);
  assign mod_addr     = bfa_pkg::ADDR_W'(mod_frame_x) << FRAME_SHIFT;
  assign used_cnt     = (limit > free_cnt_r) ? (limit - free_cnt_r) : '0;

  // read address steering
  always_comb begin
    l0_raddr = w_r;
    l1_raddr = cur_i1;
    unique case (state_r)
      S_IDLE: begin
        l0_raddr = in_word;
        l1_raddr = in_i1;
      end
      S_PICK: begin
        l1_raddr = pick_idx;
      end
      S_SUM: begin
        l0_raddr = sum_word_x[W_IDX_W-1:0];
      end
      S_CLEAR, S_MOD, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    w_nxt          = w_r;
    b_nxt          = b_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    free_cnt_nxt   = free_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    out_free_nxt   = out_free_r;
    l0_we          = 1'b0;
    l0_waddr       = w_r;
    l0_wdata       = new_word;
    l1_we          = 1'b0;
    l1_waddr       = cur_i1;
    l1_wdata       = new_sum;
    upd_en         = 1'b0;
    upd_val        = new_sum != '0;

    unique case (state_r)
      S_CLEAR: begin
        l0_we    = 1'b1;
        l0_waddr = clr_r;
        l0_wdata = '1;
        l1_we    = clr_x < XW'(N1);
        l1_waddr = clr_x[N1_W-1:0];
        l1_wdata = '0;
        clr_nxt  = clr_r + W_IDX_W'(1);
        if (clr_r == W_IDX_W'(N0 - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = bfa_pkg::op_t'(in_operation);
          w_nxt   = in_word;
          b_nxt   = in_bit;
          res_nxt = '1;
          if (bfa_pkg::op_t'(in_operation) == bfa_pkg::OP_ALLOC) begin
            state_nxt = S_PICK;
          end else if (in_range && !guarded) begin
            state_nxt = S_MOD;
          end else begin
            status_nxt = bfa_pkg::ST_NO_CHANGE;
            state_nxt  = S_OUT;
          end
        end
      end
      S_PICK: begin
        if (pick_found) begin
          w_nxt     = pick_x[W_IDX_W-1:0];
          state_nxt = S_SUM;
        end else begin
          status_nxt = bfa_pkg::ST_OUT_OF_MEMORY;
          state_nxt  = S_OUT;
        end
      end
      S_SUM: begin
        w_nxt     = sum_word_x[W_IDX_W-1:0];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (mod_change) begin
          l0_we      = 1'b1;
          l1_we      = 1'b1;
          upd_en     = 1'b1;
          status_nxt = bfa_pkg::ST_DONE;
          if (op_r == bfa_pkg::OP_ALLOC) begin
            res_nxt = mod_addr;
          end
          if (mod_set) begin
            if (free_cnt_r != '0) begin
              free_cnt_nxt = free_cnt_r - LIM_W'(1);
            end
          end else begin
            free_cnt_nxt = free_cnt_r + LIM_W'(1);
          end
        end else if (op_r == bfa_pkg::OP_ALLOC) begin
          status_nxt = bfa_pkg::ST_OUT_OF_MEMORY;
        end else begin
          status_nxt = bfa_pkg::ST_NO_CHANGE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = res_r;
          out_status_nxt = status_r;
          out_used_nxt   = bfa_pkg::CNT_W'(used_cnt);
          out_free_nxt   = bfa_pkg::CNT_W'(free_cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_CLEAR;
      clr_r             <= '0;
      free_cnt_r        <= '0;
      out_valid_r       <= 1'b0;
      total_frames_r    <= bfa_pkg::TOTAL_FRAMES_RST;
      protected_below_r <= bfa_pkg::PROTECTED_BELOW_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (bfa_pkg::cfg_idx_t'(cfg_index))
          bfa_pkg::CFG_TOTAL_FRAMES: begin
            total_frames_r <= cfg_data[bfa_pkg::CNT_W-1:0];
          end
          bfa_pkg::CFG_PROTECTED_BELOW: begin
            protected_below_r <= cfg_data[bfa_pkg::ADDR_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    w_r          <= w_nxt;
    b_r          <= b_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
  end

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (N0)
  ) u_map_ram (
    .clk   (clk),
    .we    (l0_we),
    .waddr (l0_waddr),
    .wdata (l0_wdata),
    .raddr (l0_raddr),
    .rdata (l0_rdata)
  );

  bfa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (N1)
  ) u_sum_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  bfa_summary #(
    .N (N1)
  ) u_summary (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (upd_en),
    .upd_idx    (cur_i1),
    .upd_val    (upd_val),
    .pick_found (pick_found),
    .pick_idx   (pick_idx)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_address = out_res_r;
  assign out_status         = out_status_r;
  assign out_used_count     = out_used_r;
  assign out_free_count_out = out_free_r;

endmodule

// ===== rtl/bfa_ram.sv =====
// ---------------------------------------------------------------------------
// bfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bfa_summary.sv =====
// ---------------------------------------------------------------------------
// bfa_summary
// Top-level summary bits (one per summary word with a free frame) and a
// two-stage search for the lowest set bit, registered between the stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_summary #(
  parameter int N = 128,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd_en,
  input  logic [IW-1:0] upd_idx,
  input  logic          upd_val,
  output logic          pick_found,
  output logic [IW-1:0] pick_idx
);

  localparam int G    = (N + bfa_pkg::GRP_W - 1) / bfa_pkg::GRP_W;
  localparam int P    = G * bfa_pkg::GRP_W;
  localparam int G_W  = (G > 1) ? $clog2(G) : 1;
  localparam int GB_W = $clog2(bfa_pkg::GRP_W);
  localparam int SW   = G_W + GB_W;

  logic [N-1:0]      top_r;
  logic [P-1:0]      top_pad;
  bfa_pkg::lsb_t     grp_lsb [G];
  logic [G-1:0]      grp_any_r;
  logic [GB_W-1:0]   grp_idx_r [G];
  logic [SW-1:0]     sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else if (upd_en) begin
      top_r[upd_idx] <= upd_val;
    end
  end

  assign top_pad = P'(top_r);

  always_comb begin
    for (int g = 0; g < G; g++) begin
      grp_lsb[g] = bfa_pkg::lsb64(bfa_pkg::LSB_W'(top_pad[g*bfa_pkg::GRP_W +: bfa_pkg::GRP_W]));
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < G; g++) begin
      grp_any_r[g] <= grp_lsb[g].found;
      grp_idx_r[g] <= grp_lsb[g].idx[GB_W-1:0];
    end
  end

  always_comb begin
    pick_found = 1'b0;
    sel        = '0;
    for (int g = G - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        pick_found = 1'b1;
        sel        = {G_W'(g), grp_idx_r[g]};
      end
    end
    pick_idx = IW'(sel);
  end

endmodule

// ===== rtl/bfa_checker.sv =====
// ---------------------------------------------------------------------------
// bfa_port_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bfa_pkg::ADDR_W-1:0]   out_result_address,
  input logic [bfa_pkg::STATUS_W-1:0] out_status,
  input logic [bfa_pkg::CNT_W-1:0]    out_used_count,
  input logic [bfa_pkg::CNT_W-1:0]    out_free_count_out
);

  logic                      have_last_r;
  logic [bfa_pkg::CNT_W-1:0] last_free_r;

  // free count of the previous result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_free_r <= '0;
    end else if (out_valid && !out_stall) begin
      have_last_r <= 1'b1;
      last_free_r <= out_free_count_out;
    end
  end

  `BFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_address) && $stable(out_status) && $stable(out_used_count) && $stable(out_free_count_out), "stalled result changed")

  `BFA_ASSERT(a_oom_all_ones, out_valid && (out_status == bfa_pkg::ST_OUT_OF_MEMORY), out_result_address == '1, "out of memory without all-ones address")

  `BFA_ASSERT(a_stall_after_reset, !$past(rst_n), in_stall, "input taken during map clear")

  `BFA_ASSERT(a_count_kept, out_valid && !out_stall && have_last_r && (out_status != bfa_pkg::ST_DONE), out_free_count_out == last_free_r, "free count moved on a no-op transaction")

endmodule

bind bitmap_frame_allocator bfa_port_checker u_bfa_checker (.*);

// ===== verif/bfa_checker.sv =====
// ---------------------------------------------------------------------------
// bfa_checker
// Watches the item, result and register ports of the frame allocator, keeps
// its own copy of the used-bit map, free counter and registers, works out the
// result of every accepted transaction and compares it field by field with
// what the block returns. Failures are counted and handed to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [bfa_pkg::OP_W-1:0]       in_operation,
  input  logic [bfa_pkg::ADDR_W-1:0]     in_address,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [bfa_pkg::ADDR_W-1:0]     out_result_address,
  input  logic [bfa_pkg::STATUS_W-1:0]   out_status,
  input  logic [bfa_pkg::CNT_W-1:0]      out_used_count,
  input  logic [bfa_pkg::CNT_W-1:0]      out_free_count_out,
  input  logic                           cfg_wr_en,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import bfa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } frame_result_t;

  bit                frame_used [0:MAX_FRAMES_DEF-1];
  logic [CNT_W-1:0]  free_frames;
  logic [CNT_W-1:0]  total_frames_reg;
  logic [ADDR_W-1:0] guard_addr;
  frame_result_t     pending_frame_results [$];

  function automatic int frame_limit();
    return (total_frames_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(total_frames_reg);
  endfunction

  function automatic status_t mark_frame(input logic [31:0] frame, input bit used);
    if (frame >= frame_limit())
      return ST_NO_CHANGE;
    if (frame_used[frame] == used)
      return ST_NO_CHANGE;
    frame_used[frame] = used;
    if (used) begin
      // counter never wraps below zero
      if (free_frames != '0)
        free_frames = free_frames - 1'b1;
    end else begin
      free_frames = free_frames + 1'b1;
    end
    return ST_DONE;
  endfunction

  function automatic frame_result_t predict_frame_op(input op_t op, input logic [31:0] addr);
    frame_result_t r;
    int            lim;
    int            f;
    bit            found;
    logic [31:0]   frame;
    lim   = frame_limit();
    frame = addr >> FRAME_SHIFT_DEF;
    found = 1'b0;
    r.result_address = '1;
    r.status         = ST_NO_CHANGE;
    case (op)
      OP_ALLOC: begin
        r.status = ST_OUT_OF_MEMORY;
        // first fit: lowest free frame below the limit
        for (f = 0; f < lim && !found; f++) begin
          if (!frame_used[f]) begin
            void'(mark_frame(f, 1'b1));
            r.result_address = ADDR_W'(f) << FRAME_SHIFT_DEF;
            r.status         = ST_DONE;
            found            = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (addr >= guard_addr)
          r.status = mark_frame(frame, 1'b0);
      end
      OP_RESERVE: r.status = mark_frame(frame, 1'b1);
      default:    r.status = mark_frame(frame, 1'b0);
    endcase
    // frames freed above a lowered limit still count as free
    r.used_count = (lim > free_frames) ? CNT_W'(lim - free_frames) : '0;
    r.free_count = free_frames;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t want;
    int            errs;
    int            idx;
    errs = 0;
    if (!rst_n) begin
      for (idx = 0; idx < MAX_FRAMES_DEF; idx++)
        frame_used[idx] = 1'b1;
      free_frames      = '0;
      total_frames_reg = TOTAL_FRAMES_RST;
      guard_addr       = PROTECTED_BELOW_RST;
      pending_frame_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOTAL_FRAMES:    total_frames_reg = cfg_data[CNT_W-1:0];
          CFG_PROTECTED_BELOW: guard_addr       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_frame_results.push_back(predict_frame_op(op_t'(in_operation), in_address));
      if (out_valid && !out_stall) begin
        if (pending_frame_results.size() == 0) begin
          $error("unexpected result transaction: address %h status %0d",
                 out_result_address, out_status);
          errs++;
        end else begin
          want = pending_frame_results.pop_front();
          if (out_result_address !== want.result_address) begin
            $error("result_address: expected %h, got %h", want.result_address,
                   out_result_address);
            errs++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_used_count !== want.used_count) begin
            $error("used_count: expected %0d, got %0d", want.used_count, out_used_count);
            errs++;
          end
          if (out_free_count_out !== want.free_count) begin
            $error("free_count_out: expected %0d, got %0d", want.free_count,
                   out_free_count_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= pending_frame_results.size();
    end
  end

endmodule

// ===== verif/tb_bitmap_frame_allocator.sv =====
// ---------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Drives allocate, free, reserve and release transactions into the frame
// allocator: a directed set covering the guard, range, already-in-state,
// out-of-memory and lowered-limit cases, then random phases under several
// register settings, the first four with random sender gaps and receiver
// stalls. The checker beside the block predicts; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASE_ITEMS    = 150;
  localparam int N_PHASES       = 6;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = OP_ALLOC;
  logic [ADDR_W-1:0]     in_address   = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [ADDR_W-1:0]     out_result_address;
  logic [STATUS_W-1:0]   out_status;
  logic [CNT_W-1:0]      out_used_count;
  logic [CNT_W-1:0]      out_free_count_out;
  logic                  cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_TOTAL_FRAMES;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned watchdog       = 0;
  int unsigned recv_calm      = 0;
  int unsigned send_calm      = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          limit_now      = 65536;

  int          phase_total [N_PHASES] = '{48, 65536, 1, 200, 65536, 130};
  logic [31:0] phase_guard [N_PHASES] = '{32'h0000_8000, 32'h0000_0000, 32'h0000_1000,
                                          32'hFFFF_FFFF, 32'h0002_0000, 32'h0004_0000};

  bitmap_frame_allocator u_top (.*);
  bfa_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls, with occasional stall-free stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_calm <= 0;
    end else if (recv_calm != 0) begin
      recv_calm <= recv_calm - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(99) < 3) begin
      recv_calm <= $urandom_range(30, 10);
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      watchdog <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  task automatic send_item(input op_t op, input logic [31:0] addr);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    do @(posedge clk); while (in_stall);
    if (send_calm != 0) begin
      send_calm--;
    end else if ($urandom_range(99) < 4) begin
      send_calm = $urandom_range(20, 8);
    end else if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // hold off until every outstanding transaction has returned
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] total, input logic [31:0] guard);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TOTAL_FRAMES;
    cfg_data  <= total;
    @(posedge clk);
    cfg_index <= CFG_PROTECTED_BELOW;
    cfg_data  <= guard;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = (total > 65536) ? 65536 : int'(total);
  endtask

  function automatic logic [31:0] pick_address();
    logic [19:0] frame;
    int          window;
    int          roll;
    roll   = $urandom_range(99);
    window = (limit_now < 96) ? limit_now + 4 : 96;
    if (roll < 10)
      return $urandom();
    if (roll < 22)
      frame = 20'(limit_now - 4 + $urandom_range(7));
    else
      frame = 20'($urandom_range(window - 1));
    return {frame, 12'($urandom())};
  endfunction

  function automatic op_t pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30)
      return OP_ALLOC;
    if (roll < 52)
      return OP_FREE;
    if (roll < 67)
      return OP_RESERVE;
    return OP_RELEASE;
  endfunction

  initial begin : stimulus
    int ph;
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 36;
    recv_stall_pct = 69;

    // directed: limit 64, guard at frame 16
    set_config(64, 32'h0001_0000);
    send_item(OP_ALLOC, '0);
    send_item(OP_RELEASE, 32'h0000_3000);
    send_item(OP_RELEASE, 32'h0000_3000);
    send_item(OP_RELEASE, 32'h0004_0000);
    send_item(OP_FREE, 32'h0000_FFFF);
    send_item(OP_FREE, 32'h0001_0000);
    send_item(OP_FREE, 32'h0001_0FFF);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_RESERVE, 32'h0000_3000);
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_RESERVE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h0003_F123);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 32'hFFFF_FFFF);
    send_item(OP_RESERVE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'h0002_8000);
    send_item(OP_RELEASE, 32'h0002_9000);
    // lowered limit leaves free frames above it
    drain();
    set_config(32, 32'h0001_0000);
    send_item(OP_ALLOC, '0);
    drain();
    set_config(0, 32'h0001_0000);
    send_item(OP_ALLOC, '0);
    send_item(OP_RESERVE, 32'h0000_0000);
    drain();
    set_config(65536, 32'hFFFF_FFFF);
    send_item(OP_FREE, 32'hFFFF_EFFF);
    send_item(OP_ALLOC, '0);
    drain();
    set_config(65536, 32'h0000_0000);
    send_item(OP_FREE, 32'h0000_0000);

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct  = 36;
        recv_stall_pct = 69;
      end else if (ph < 4) begin
        send_idle_pct  = 69;
        recv_stall_pct = 36;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      drain();
      set_config(phase_total[ph], phase_guard[ph]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) == 0)
          drain();
        send_item(pick_op(), pick_address());
      end
    end

    drain();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_summary.sv
rtl/bitmap_frame_allocator.sv
rtl/bfa_checker.sv
verif/bfa_checker.sv
verif/tb_bitmap_frame_allocator.sv
